/* hdl/assert_macros.svh */
// Assertion macros shared by the clock RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define WCC_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// The antecedent implies the consequent at the same edge.
`define WCC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent at the next edge.
`define WCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/wcc_pkg.sv */
`timescale 1ns / 1ps

package wcc_pkg;

    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_LOAD = 2'd1,
        MODE_DATE = 2'd2,
        MODE_LAMP = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        VIEW_NONE     = 2'd0,
        VIEW_SHORT    = 2'd1,
        VIEW_EXTENDED = 2'd2,
        VIEW_DATE     = 2'd3
    } view_t;

    typedef enum logic [1:0] {
        BEEP_NONE  = 2'd0,
        BEEP_SHORT = 2'd1,
        BEEP_LONG  = 2'd2
    } beep_t;

    localparam logic [1:0] REG_DISPLAY_ON       = 2'd0;
    localparam logic [1:0] REG_CHIME_FIRST_HOUR = 2'd1;
    localparam logic [1:0] REG_CHIME_LAST_HOUR  = 2'd2;
    localparam logic [1:0] REG_DATE_SHOW_TICKS  = 2'd3;

    localparam logic       RST_DISPLAY_ON       = 1'b0;
    localparam logic [4:0] RST_CHIME_FIRST_HOUR = 5'd8;
    localparam logic [4:0] RST_CHIME_LAST_HOUR  = 5'd22;
    localparam logic [2:0] RST_DATE_SHOW_TICKS  = 3'd4;

    localparam logic [4:0] MAX_HOURS      = 5'd23;
    localparam logic [5:0] MAX_MINSEC     = 6'd59;
    localparam logic [5:0] HALF_MINUTE_LO = 6'd29;
    localparam logic [5:0] HALF_MINUTE    = 6'd30;
    localparam logic [5:0] EXT_LATE_SEC   = 6'd55;
    localparam logic [5:0] EXT_EARLY_SEC  = 6'd5;
    localparam logic [5:0] CHIME_LATE_SEC = 6'd56;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef struct packed {
        logic       display_on;
        logic [4:0] chime_first_hour;
        logic [4:0] chime_last_hour;
        logic [2:0] date_show_ticks;
    } cfg_t;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       colon_lit;
        view_t      view;
        beep_t      beep;
        logic       lamp_test;
    } result_t;

endpackage

/* hdl/wcc_cfg.sv */
`timescale 1ns / 1ps

module wcc_cfg
    import wcc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[3:2])
                REG_DISPLAY_ON:       cfg_next.display_on       = pwdata[0];
                REG_CHIME_FIRST_HOUR: cfg_next.chime_first_hour = pwdata[4:0];
                REG_CHIME_LAST_HOUR:  cfg_next.chime_last_hour  = pwdata[4:0];
                REG_DATE_SHOW_TICKS:  cfg_next.date_show_ticks  = pwdata[2:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.display_on       <= RST_DISPLAY_ON;
            cfg_reg.chime_first_hour <= RST_CHIME_FIRST_HOUR;
            cfg_reg.chime_last_hour  <= RST_CHIME_LAST_HOUR;
            cfg_reg.date_show_ticks  <= RST_DATE_SHOW_TICKS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DISPLAY_ON:       prdata = {{(PDATA_W-1){1'b0}}, cfg_reg.display_on};
            REG_CHIME_FIRST_HOUR: prdata = {{(PDATA_W-5){1'b0}}, cfg_reg.chime_first_hour};
            REG_CHIME_LAST_HOUR:  prdata = {{(PDATA_W-5){1'b0}}, cfg_reg.chime_last_hour};
            REG_DATE_SHOW_TICKS:  prdata = {{(PDATA_W-3){1'b0}}, cfg_reg.date_show_ticks};
            default:              prdata = '0;
        endcase
    end

endmodule

/* hdl/wcc_core.sv */
`timescale 1ns / 1ps

module wcc_core
    import wcc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  mode_t      mode,
    input  logic [4:0] load_hours,
    input  logic [5:0] load_minutes,
    input  logic [5:0] load_seconds,
    input  cfg_t       cfg,
    output result_t    result
);

    `include "assert_macros.svh"

    logic [4:0] hours_reg, hours_next;
    logic [5:0] minutes_reg, minutes_next;
    logic [5:0] seconds_reg, seconds_next;
    logic       colon_reg, colon_next;
    logic       extended_reg, extended_next;
    logic       chime_armed_reg, chime_armed_next;
    logic [2:0] date_count_reg, date_count_next;
    logic       test_pending_reg, test_pending_next;

    logic [4:0] adv_hours;
    logic [5:0] adv_minutes;
    logic [5:0] adv_seconds;
    logic       in_chime_window;

    // Time after one second has passed.
    always_comb begin
        adv_hours   = hours_reg;
        adv_minutes = minutes_reg;
        adv_seconds = seconds_reg + 6'd1;
        if (seconds_reg >= MAX_MINSEC) begin
            adv_seconds = '0;
            adv_minutes = minutes_reg + 6'd1;
            if (minutes_reg >= MAX_MINSEC) begin
                adv_minutes = '0;
                adv_hours   = (hours_reg >= MAX_HOURS) ? 5'd0 : hours_reg + 5'd1;
            end
        end
    end

    assign in_chime_window = (hours_reg >= cfg.chime_first_hour) &&
                             (hours_reg <= cfg.chime_last_hour) && chime_armed_reg;

    always_comb begin
        hours_next        = hours_reg;
        minutes_next      = minutes_reg;
        seconds_next      = seconds_reg;
        colon_next        = colon_reg;
        extended_next     = extended_reg;
        chime_armed_next  = chime_armed_reg;
        date_count_next   = date_count_reg;
        test_pending_next = test_pending_reg;
        result.view       = VIEW_NONE;
        result.beep       = BEEP_NONE;
        result.lamp_test  = 1'b0;

        case (mode)
            MODE_LOAD: begin
                hours_next   = (load_hours   > MAX_HOURS)  ? MAX_HOURS  : load_hours;
                minutes_next = (load_minutes > MAX_MINSEC) ? MAX_MINSEC : load_minutes;
                seconds_next = (load_seconds > MAX_MINSEC) ? MAX_MINSEC : load_seconds;
            end
            MODE_DATE: begin
                date_count_next = cfg.date_show_ticks;
            end
            MODE_LAMP: begin
                test_pending_next = 1'b1;
            end
            MODE_TICK: begin
                if (cfg.display_on) begin
                    if (date_count_reg != 3'd0) begin
                        date_count_next = date_count_reg - 3'd1;
                        result.view     = VIEW_DATE;
                    end else begin
                        result.view = extended_reg ? VIEW_EXTENDED : VIEW_SHORT;
                    end
                    if (in_chime_window) begin
                        result.beep = (minutes_reg == 6'd0 && seconds_reg == 6'd0) ?
                                      BEEP_LONG : BEEP_SHORT;
                    end
                end
                result.lamp_test  = test_pending_reg;
                test_pending_next = 1'b0;
                colon_next        = ~colon_reg;
                hours_next        = adv_hours;
                minutes_next      = adv_minutes;
                seconds_next      = adv_seconds;
                extended_next = (((adv_minutes == MAX_MINSEC) ||
                                  (adv_minutes == HALF_MINUTE_LO)) &&
                                 (adv_seconds >= EXT_LATE_SEC)) ||
                                (((adv_minutes == 6'd0) || (adv_minutes == HALF_MINUTE)) &&
                                 (adv_seconds <= EXT_EARLY_SEC));
                chime_armed_next = ((adv_minutes == MAX_MINSEC) &&
                                    (adv_seconds >= CHIME_LATE_SEC)) ||
                                   ((adv_minutes == 6'd0) && (adv_seconds == 6'd0));
            end
            default: begin
                hours_next = hours_reg;
            end
        endcase

        // A tick reports the time before its advance; other words report the new state.
        if (mode == MODE_TICK) begin
            result.hours     = hours_reg;
            result.minutes   = minutes_reg;
            result.seconds   = seconds_reg;
            result.colon_lit = colon_reg;
        end else begin
            result.hours     = hours_next;
            result.minutes   = minutes_next;
            result.seconds   = seconds_next;
            result.colon_lit = colon_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hours_reg        <= '0;
            minutes_reg      <= '0;
            seconds_reg      <= '0;
            colon_reg        <= 1'b0;
            extended_reg     <= 1'b0;
            chime_armed_reg  <= 1'b0;
            date_count_reg   <= '0;
            test_pending_reg <= 1'b0;
        end else if (in_fire) begin
            hours_reg        <= hours_next;
            minutes_reg      <= minutes_next;
            seconds_reg      <= seconds_next;
            colon_reg        <= colon_next;
            extended_reg     <= extended_next;
            chime_armed_reg  <= chime_armed_next;
            date_count_reg   <= date_count_next;
            test_pending_reg <= test_pending_next;
        end
    end

    `WCC_ASSERT_ALWAYS(a_hours_range, aclk, aresetn, hours_reg <= MAX_HOURS, "hours out of range")
    `WCC_ASSERT_ALWAYS(a_minutes_range, aclk, aresetn, minutes_reg <= MAX_MINSEC, "minutes out of range")
    `WCC_ASSERT_ALWAYS(a_seconds_range, aclk, aresetn, seconds_reg <= MAX_MINSEC, "seconds out of range")

endmodule

/* hdl/wall_clock_with_chime.sv */
`timescale 1ns / 1ps

// Seconds-driven wall clock with an hourly chime. Every input word (tick, time load, date request or
// lamp-test request) yields exactly one result word, registered and presented in the cycle after
// acceptance. The block takes one word per clock cycle; the only thing that holds it back is the
// single output register, which accepts a new word in the same cycle as the held one is taken.
// The user writes configuration through the APB port only while no word is in flight (not enforced).

module wall_clock_with_chime
    import wcc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [4:0]         s_load_hours,
    input  logic [5:0]         s_load_minutes,
    input  logic [5:0]         s_load_seconds,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [4:0]         m_shown_hours,
    output logic [5:0]         m_shown_minutes,
    output logic [5:0]         m_shown_seconds,
    output logic               m_colon_lit,
    output logic [1:0]         m_view,
    output logic [1:0]         m_beep,
    output logic               m_lamp_test
);

    `include "assert_macros.svh"

    cfg_t    cfg;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    in_fire;

    assign s_ready = !out_valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;

    wcc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wcc_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_fire      (in_fire),
        .mode         (mode_t'(s_mode)),
        .load_hours   (s_load_hours),
        .load_minutes (s_load_minutes),
        .load_seconds (s_load_seconds),
        .cfg          (cfg),
        .result       (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_ready) begin
            out_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            out_reg <= result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_shown_hours   = out_reg.hours;
    assign m_shown_minutes = out_reg.minutes;
    assign m_shown_seconds = out_reg.seconds;
    assign m_colon_lit     = out_reg.colon_lit;
    assign m_view          = out_reg.view;
    assign m_beep          = out_reg.beep;
    assign m_lamp_test     = out_reg.lamp_test;

    `WCC_ASSERT_NEXT(a_accept_gives_word, aclk, aresetn, in_fire, m_valid, "accepted word lost")
    `WCC_ASSERT_SAME(a_beep_needs_view, aclk, aresetn, m_valid && (m_beep != BEEP_NONE), m_view != VIEW_NONE, "beep without a view")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import wcc_pkg::*;

    typedef enum logic {
        ROW_WORD,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        mode_t      mode;
        logic [4:0] load_h;
        logic [5:0] load_m;
        logic [5:0] load_s;
        logic [7:0] reps;
        logic       pinned;
        result_t    face;
        logic [1:0] reg_idx;
        logic [4:0] reg_val;
    } script_row_t;

    localparam int SCRIPT_LEN   = 28;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 250;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_mode = MODE_TICK;
    logic [4:0]         s_load_hours = '0;
    logic [5:0]         s_load_minutes = '0;
    logic [5:0]         s_load_seconds = '0;
    logic               m_valid;
    logic               m_ready = 1'b1;
    logic [4:0]         m_shown_hours;
    logic [5:0]         m_shown_minutes;
    logic [5:0]         m_shown_seconds;
    logic               m_colon_lit;
    logic [1:0]         m_view;
    logic [1:0]         m_beep;
    logic               m_lamp_test;

    wall_clock_with_chime DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_load_hours    (s_load_hours),
        .s_load_minutes  (s_load_minutes),
        .s_load_seconds  (s_load_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_shown_hours   (m_shown_hours),
        .m_shown_minutes (m_shown_minutes),
        .m_shown_seconds (m_shown_seconds),
        .m_colon_lit     (m_colon_lit),
        .m_view          (m_view),
        .m_beep          (m_beep),
        .m_lamp_test     (m_lamp_test)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    cfg_t       cfg_copy;
    logic [4:0] clk_hours;
    logic [5:0] clk_minutes;
    logic [5:0] clk_seconds;
    logic       clk_colon;
    logic       near_mark;
    logic       chime_due;
    logic [2:0] date_left;
    logic       lamp_due;

    result_t     expected_faces[$];
    logic        word_pinned = 1'b0;
    result_t     pinned_face = '0;
    script_row_t script_rows[SCRIPT_LEN];

    int mismatches = 0;
    int words_taken = 0;
    int faces_checked = 0;
    int long_beeps = 0;
    int short_beeps = 0;
    int date_views = 0;
    int lamp_tests = 0;
    int settings_written = 0;
    int burst_left = 0;
    int stall_left = 0;
    logic [15:0] stall_mask = 16'hFFFF;

    function automatic result_t advance_clock(mode_t md, logic [4:0] lh, logic [5:0] lm,
                                              logic [5:0] ls);
        result_t face;
        face = '0;
        if (md == MODE_TICK) begin
            if (cfg_copy.display_on) begin
                if (date_left != 3'd0) begin
                    date_left = date_left - 3'd1;
                    face.view = VIEW_DATE;
                end else begin
                    face.view = near_mark ? VIEW_EXTENDED : VIEW_SHORT;
                end
                if (clk_hours >= cfg_copy.chime_first_hour &&
                    clk_hours <= cfg_copy.chime_last_hour && chime_due) begin
                    face.beep = (clk_minutes == 6'd0 && clk_seconds == 6'd0) ? BEEP_LONG
                                                                             : BEEP_SHORT;
                end
            end
            face.lamp_test = lamp_due;
            lamp_due = 1'b0;
            face.hours = clk_hours;
            face.minutes = clk_minutes;
            face.seconds = clk_seconds;
            face.colon_lit = clk_colon;
            clk_colon = ~clk_colon;
            if (clk_seconds >= MAX_MINSEC) begin
                clk_seconds = 6'd0;
                if (clk_minutes >= MAX_MINSEC) begin
                    clk_minutes = 6'd0;
                    clk_hours = (clk_hours >= MAX_HOURS) ? 5'd0 : clk_hours + 5'd1;
                end else begin
                    clk_minutes = clk_minutes + 6'd1;
                end
            end else begin
                clk_seconds = clk_seconds + 6'd1;
            end
            near_mark = ((clk_minutes == MAX_MINSEC || clk_minutes == HALF_MINUTE_LO) &&
                         clk_seconds >= EXT_LATE_SEC) ||
                        ((clk_minutes == 6'd0 || clk_minutes == HALF_MINUTE) &&
                         clk_seconds <= EXT_EARLY_SEC);
            chime_due = (clk_minutes == MAX_MINSEC && clk_seconds >= CHIME_LATE_SEC) ||
                        (clk_minutes == 6'd0 && clk_seconds == 6'd0);
        end else begin
            case (md)
                MODE_LOAD: begin
                    clk_hours = (lh > MAX_HOURS) ? MAX_HOURS : lh;
                    clk_minutes = (lm > MAX_MINSEC) ? MAX_MINSEC : lm;
                    clk_seconds = (ls > MAX_MINSEC) ? MAX_MINSEC : ls;
                end
                MODE_DATE: date_left = cfg_copy.date_show_ticks;
                default:   lamp_due = 1'b1;
            endcase
            face.hours = clk_hours;
            face.minutes = clk_minutes;
            face.seconds = clk_seconds;
            face.colon_lit = clk_colon;
        end
        return face;
    endfunction

    function automatic result_t face_at(logic [4:0] h, logic [5:0] mi, logic [5:0] se,
                                        logic colon, logic lamp);
        result_t f;
        f = '0;
        f.hours = h;
        f.minutes = mi;
        f.seconds = se;
        f.colon_lit = colon;
        f.lamp_test = lamp;
        return f;
    endfunction

    function automatic script_row_t word_row(mode_t md, logic [4:0] h, logic [5:0] mi,
                                             logic [5:0] se, logic [7:0] reps);
        script_row_t r;
        r = '0;
        r.kind = ROW_WORD;
        r.mode = md;
        r.load_h = h;
        r.load_m = mi;
        r.load_s = se;
        r.reps = reps;
        return r;
    endfunction

    function automatic script_row_t pinned_row(mode_t md, logic [4:0] h, logic [5:0] mi,
                                               logic [5:0] se, result_t f);
        script_row_t r;
        r = word_row(md, h, mi, se, 8'd1);
        r.pinned = 1'b1;
        r.face = f;
        return r;
    endfunction

    function automatic script_row_t reg_row(logic [1:0] idx, logic [4:0] val);
        script_row_t r;
        r = '0;
        r.kind = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : watch_ports
        result_t face;
        result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                face = advance_clock(mode_t'(s_mode), s_load_hours, s_load_minutes,
                                     s_load_seconds);
                expected_faces.push_back(word_pinned ? pinned_face : face);
                words_taken++;
            end
            if (m_valid && m_ready) begin
                if (expected_faces.size() == 0) begin
                    $error("result word arrived with none expected");
                    mismatches++;
                end else begin
                    want = expected_faces.pop_front();
                    check_field("shown_hours", want.hours, m_shown_hours);
                    check_field("shown_minutes", want.minutes, m_shown_minutes);
                    check_field("shown_seconds", want.seconds, m_shown_seconds);
                    check_field("colon_lit", want.colon_lit, m_colon_lit);
                    check_field("view", want.view, m_view);
                    check_field("beep", want.beep, m_beep);
                    check_field("lamp_test", want.lamp_test, m_lamp_test);
                    faces_checked++;
                    if (want.beep == BEEP_LONG) long_beeps++;
                    if (want.beep == BEEP_SHORT) short_beeps++;
                    if (want.view == VIEW_DATE) date_views++;
                    if (want.lamp_test) lamp_tests++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            stall_left = 64;
        end
        stall_left = stall_left - 1;
        m_ready = stall_mask[stall_left[3:0]];
    end

    task automatic send_word(input mode_t md, input logic [4:0] h, input logic [5:0] mi,
                             input logic [5:0] se, input logic pin, input result_t f);
        int gap;
        @(negedge aclk);
        s_valid = 1'b1;
        s_mode = md;
        s_load_hours = h;
        s_load_minutes = mi;
        s_load_seconds = se;
        word_pinned = pin;
        pinned_face = f;
        do @(posedge aclk); while (!s_ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    task automatic wait_for_drain;
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_faces.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] want;
        want = '0;
        @(negedge aclk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_DISPLAY_ON: begin
                cfg_copy.display_on = value[0];
                want = 32'(value[0]);
            end
            REG_CHIME_FIRST_HOUR: begin
                cfg_copy.chime_first_hour = value[4:0];
                want = 32'(value[4:0]);
            end
            REG_CHIME_LAST_HOUR: begin
                cfg_copy.chime_last_hour = value[4:0];
                want = 32'(value[4:0]);
            end
            default: begin
                cfg_copy.date_show_ticks = value[2:0];
                want = 32'(value[2:0]);
            end
        endcase
        settings_written++;
        @(negedge aclk);
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            $error("register %0d readback: expected %0d, actual %0d", idx, want, prdata);
            mismatches++;
        end
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic send_random_word;
        int pick;
        logic [4:0] h;
        logic [5:0] mi;
        logic [5:0] se;
        mode_t md;
        h = 5'($urandom);
        mi = 6'($urandom);
        se = 6'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            md = MODE_TICK;
        end else if (pick < 88) begin
            md = MODE_LOAD;
            case ($urandom_range(0, 3))
                0: ;
                1: begin
                    h = 5'($urandom_range(0, 23));
                    mi = ($urandom_range(0, 1) != 0) ? MAX_MINSEC : HALF_MINUTE_LO;
                    se = 6'($urandom_range(48, 59));
                end
                2: begin
                    h = ($urandom_range(0, 1) != 0) ? cfg_copy.chime_first_hour - 5'd1
                                                    : cfg_copy.chime_last_hour;
                    mi = MAX_MINSEC;
                    se = 6'($urandom_range(50, 59));
                end
                default: begin
                    h = MAX_HOURS;
                    mi = MAX_MINSEC;
                    se = 6'($urandom_range(45, 59));
                end
            endcase
        end else if (pick < 95) begin
            md = MODE_DATE;
        end else begin
            md = MODE_LAMP;
        end
        send_word(md, h, mi, se, 1'b0, '0);
    endtask

    initial begin : stimulus
        int row;
        int rep;
        int phase;
        int n;
        logic [4:0] first_hour;
        logic [4:0] last_hour;

        cfg_copy = {RST_DISPLAY_ON, RST_CHIME_FIRST_HOUR, RST_CHIME_LAST_HOUR,
                    RST_DATE_SHOW_TICKS};
        clk_hours = '0;
        clk_minutes = '0;
        clk_seconds = '0;
        clk_colon = 1'b0;
        near_mark = 1'b0;
        chime_due = 1'b0;
        date_left = '0;
        lamp_due = 1'b0;

        script_rows = '{
            pinned_row(MODE_TICK, 5'd0, 6'd0, 6'd0, face_at(5'd0, 6'd0, 6'd0, 1'b0, 1'b0)),
            pinned_row(MODE_LAMP, 5'd0, 6'd0, 6'd0, face_at(5'd0, 6'd0, 6'd1, 1'b1, 1'b0)),
            pinned_row(MODE_LAMP, 5'd31, 6'd63, 6'd63,
                       face_at(5'd0, 6'd0, 6'd1, 1'b1, 1'b0)),
            pinned_row(MODE_TICK, 5'd0, 6'd0, 6'd0, face_at(5'd0, 6'd0, 6'd1, 1'b1, 1'b1)),
            word_row(MODE_TICK, 5'd0, 6'd0, 6'd0, 8'd1),
            pinned_row(MODE_LOAD, 5'd31, 6'd63, 6'd63,
                       face_at(5'd23, 6'd59, 6'd59, 1'b1, 1'b0)),
            word_row(MODE_DATE, 5'd0, 6'd0, 6'd0, 8'd1),
            word_row(MODE_TICK, 5'd0, 6'd0, 6'd0, 8'd1),
            reg_row(REG_DISPLAY_ON, 5'd1),
            word_row(MODE_TICK, 5'd0, 6'd0, 6'd0, 8'd1),
            word_row(MODE_LOAD, 5'd8, 6'd59, 6'd54, 8'd1),
            word_row(MODE_TICK, 5'd0, 6'd0, 6'd0, 8'd7),
            reg_row(REG_DATE_SHOW_TICKS, 5'd0),
            word_row(MODE_DATE, 5'd0, 6'd0, 6'd0, 8'd1),
            word_row(MODE_TICK, 5'd0, 6'd0, 6'd0, 8'd1),
            word_row(MODE_LOAD, 5'd22, 6'd29, 6'd55, 8'd1),
            word_row(MODE_TICK, 5'd0, 6'd0, 6'd0, 8'd2),
            reg_row(REG_CHIME_FIRST_HOUR, 5'd23),
            reg_row(REG_CHIME_LAST_HOUR, 5'd0),
            word_row(MODE_LOAD, 5'd23, 6'd59, 6'd57, 8'd1),
            word_row(MODE_TICK, 5'd0, 6'd0, 6'd0, 8'd3),
            reg_row(REG_CHIME_FIRST_HOUR, 5'd0),
            reg_row(REG_CHIME_LAST_HOUR, 5'd23),
            reg_row(REG_DATE_SHOW_TICKS, 5'd7),
            word_row(MODE_DATE, 5'd0, 6'd0, 6'd0, 8'd1),
            word_row(MODE_LAMP, 5'd0, 6'd0, 6'd0, 8'd1),
            word_row(MODE_TICK, 5'd0, 6'd0, 6'd0, 8'd1),
            reg_row(REG_DISPLAY_ON, 5'd0)
        };

        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        for (row = 0; row < SCRIPT_LEN; row++) begin
            if (script_rows[row].kind == ROW_REG) begin
                wait_for_drain();
                write_register(script_rows[row].reg_idx, 32'(script_rows[row].reg_val));
            end else begin
                for (rep = 0; rep < int'(script_rows[row].reps); rep++) begin
                    send_word(script_rows[row].mode, script_rows[row].load_h,
                              script_rows[row].load_m, script_rows[row].load_s,
                              script_rows[row].pinned, script_rows[row].face);
                end
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            wait_for_drain();
            case (phase)
                0: begin
                    write_register(REG_DISPLAY_ON, 32'd1);
                    write_register(REG_CHIME_FIRST_HOUR, 32'd0);
                    write_register(REG_CHIME_LAST_HOUR, 32'd23);
                    write_register(REG_DATE_SHOW_TICKS, 32'd7);
                end
                1: begin
                    write_register(REG_DISPLAY_ON, 32'd1);
                    write_register(REG_CHIME_FIRST_HOUR, 32'd23);
                    write_register(REG_CHIME_LAST_HOUR, 32'd0);
                    write_register(REG_DATE_SHOW_TICKS, 32'd0);
                end
                default: begin
                    first_hour = 5'($urandom_range(0, 23));
                    last_hour = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 23))
                                                            : 5'($urandom_range(first_hour, 23));
                    write_register(REG_DISPLAY_ON,
                                   (phase == 2) ? 32'd0 : 32'($urandom_range(0, 4) != 0));
                    write_register(REG_CHIME_FIRST_HOUR, 32'(first_hour));
                    write_register(REG_CHIME_LAST_HOUR, 32'(last_hour));
                    write_register(REG_DATE_SHOW_TICKS, 32'($urandom_range(0, 7)));
                end
            endcase
            for (n = 0; n < PHASE_WORDS; n++) begin
                if (n == PHASE_WORDS / 2) wait_for_drain();
                send_random_word();
            end
        end

        wait_for_drain();
        repeat (8) @(posedge aclk);

        $display("Checked %0d result words against %0d input words, %0d register writes.",
                 faces_checked, words_taken, settings_written);
        $display("Seen: %0d long and %0d short chimes, %0d date views, %0d lamp tests.",
                 long_beeps, short_beeps, date_views, lamp_tests);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
